[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the delayed action timer table.
// Each macro expands to one labeled concurrent assertion on a clock/reset pair.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dat_pkg.sv]
// Package for the delayed action timer table: command and status codes,
// slot and result types. No dependencies.
`default_nettype none

package dat_pkg;

    localparam int ACT_W      = 8;
    localparam int ARG_W      = 16;
    localparam int KIND_W     = 2;
    localparam int TIME_W     = 16;
    localparam int REM_W      = 18;
    localparam int SLOT_IDX_W = 5;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;

    localparam logic [CMD_W-1:0] CMD_START_DAEMON = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START_FUSE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LENGTHEN     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RUN_DAEMONS  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RUN_FUSES    = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;

    // Remaining time of a daemon, and the saturation bounds
    localparam logic signed [REM_W-1:0] REM_DAEMON = -18'sd1;
    localparam logic signed [REM_W-1:0] REM_MAX    = 18'sd131071;
    localparam logic signed [REM_W-1:0] REM_MIN    = -18'sd131072;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [ACT_W-1:0]         action;
        logic signed [ARG_W-1:0]  argument;
        logic signed [REM_W-1:0]  remaining;
    } t_slot;

    typedef struct packed {
        logic                     fired;
        logic [ACT_W-1:0]         action;
        logic signed [ARG_W-1:0]  argument;
        logic [SLOT_IDX_W-1:0]    slot_index;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } t_result;

endpackage

`default_nettype wire

[rtl/dat_cell.sv]
// One slot cell of the timer ring: holds a slot and hands it to its
// neighbor on every shift. Depends on dat_pkg.
`default_nettype none

module dat_cell
    import dat_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_shift,
    input  wire t_slot i_slot,
    output t_slot      o_slot
);

    logic [KIND_W-1:0]       r_kind;
    logic [ACT_W-1:0]        r_action;
    logic signed [ARG_W-1:0] r_argument;
    logic signed [REM_W-1:0] r_remaining;

    // Clear the kind on reset so every slot starts empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_EMPTY;
        end else if (i_shift) begin
            r_kind <= i_slot.kind;
        end
    end

    // Take the payload from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_action    <= i_slot.action;
            r_argument  <= i_slot.argument;
            r_remaining <= i_slot.remaining;
        end
    end

    assign o_slot = '{kind: r_kind, action: r_action, argument: r_argument,
                      remaining: r_remaining};

endmodule

`default_nettype wire

[rtl/dat_head.sv]
// Head unit of the timer ring: applies the current command to the slot at
// the head of the ring and flags a result. Depends on dat_pkg.
`default_nettype none

module dat_head
    import dat_pkg::*;
(
    input  wire logic [CMD_W-1:0]        i_cmd,
    input  wire logic [ACT_W-1:0]        i_action_id,
    input  wire logic signed [ARG_W-1:0] i_argument,
    input  wire logic [KIND_W-1:0]       i_kind,
    input  wire logic [TIME_W-1:0]       i_fuse_time,
    input  wire logic signed [TIME_W-1:0] i_time_delta,
    input  wire logic                    i_found,
    input  wire t_slot                   i_slot,
    output t_slot                        o_slot,
    output logic                         o_hit
);

    logic                      w_occupied;
    logic                      w_kind_sel;
    logic signed [REM_W:0]     w_sum;
    logic signed [REM_W-1:0]   w_sat;

    assign w_occupied = (i_slot.kind != KIND_EMPTY);
    assign w_kind_sel = (i_kind != KIND_EMPTY) && (i_slot.kind == i_kind);

    // Lengthen: widen, add, saturate on overflow
    assign w_sum = {i_slot.remaining[REM_W-1], i_slot.remaining}
                 + (REM_W+1)'(i_time_delta);
    always_comb begin
        if (w_sum[REM_W] != w_sum[REM_W-1]) begin
            w_sat = w_sum[REM_W] ? REM_MIN : REM_MAX;
        end else begin
            w_sat = w_sum[REM_W-1:0];
        end
    end

    // Update the head slot for the command in flight
    always_comb begin
        o_slot = i_slot;
        o_hit  = 1'b0;
        unique case (i_cmd) inside
            CMD_START_DAEMON, CMD_START_FUSE: begin
                if (!i_found && !w_occupied) begin
                    o_hit           = 1'b1;
                    o_slot.kind     = i_kind;
                    o_slot.action   = i_action_id;
                    o_slot.argument = i_argument;
                    o_slot.remaining = (i_cmd == CMD_START_DAEMON) ? REM_DAEMON
                                     : $signed({2'b00, i_fuse_time});
                end
            end
            CMD_REMOVE: begin
                if (!i_found && w_occupied && i_slot.action == i_action_id) begin
                    o_hit       = 1'b1;
                    o_slot.kind = KIND_EMPTY;
                end
            end
            CMD_LENGTHEN: begin
                if (!i_found && w_occupied && i_slot.action == i_action_id) begin
                    o_hit            = 1'b1;
                    o_slot.remaining = w_sat;
                end
            end
            CMD_RUN_DAEMONS: begin
                o_hit = w_kind_sel && (i_slot.remaining == REM_DAEMON);
            end
            CMD_RUN_FUSES: begin
                if (w_kind_sel && i_slot.remaining > 0) begin
                    o_slot.remaining = i_slot.remaining - REM_W'(1);
                    if (i_slot.remaining == REM_W'(1)) begin
                        o_hit       = 1'b1;
                        o_slot.kind = KIND_EMPTY;
                    end
                end
            end
            default: begin
                o_hit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/delayed_action_timer_table_unit.sv]
// Top level of the delayed action timer table: a ring of slot cells, the
// head unit and the command sequencer. Depends on dat_pkg, dat_cell, dat_head.
//
// The table is a ring of SLOTS cells that rotates by one slot per cycle
// while a command runs, unless a stall holds it; the head unit looks at
// one slot per cycle and writes it back at the tail, so a full rotation
// restores slot order. Every command is taken in the idle state, rotates
// through all SLOTS slots in the pass state and finishes in the done
// state; the ring stalls while a result waits because the output register
// is still held by the sink, and the done state waits for a free one too.
// A new command is taken only when the previous one has finished. Fire
// results leave in slot order; the final result of a command carries tlast.
// Commands that give no result (run with kind zero, run with nothing to
// fire, unused codes) still take the full rotation.
// Reset empties all slots at once; no clearing pass is needed.
`default_nettype none

module delayed_action_timer_table_unit
    import dat_pkg::*;
#(
    parameter int SLOTS = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: action_id[7:0], argument[23:8], fuse_time[39:24], time_delta[55:40]
    input  wire logic [55:0] s_axis_tdata,
    // tuser: command[2:0], kind[4:3]
    input  wire logic [4:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: fired_action[7:0], fired_argument[23:8], slot_index[28:24],
    //        status[30:29], zero[31]
    output logic [31:0]      m_axis_tdata,
    // tuser: fired[0]
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    `include "assert_macros.svh"

    localparam int CW = $clog2(SLOTS);
    localparam logic [CW-1:0] LAST_SLOT = CW'(SLOTS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PASS = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Command registers
    logic [CMD_W-1:0]         r_cmd;
    logic [ACT_W-1:0]         r_action_id;
    logic signed [ARG_W-1:0]  r_argument;
    logic [KIND_W-1:0]        r_kind;
    logic [TIME_W-1:0]        r_fuse_time;
    logic signed [TIME_W-1:0] r_time_delta;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_pend_valid, n_pend_valid;
    t_result       r_pend, n_pend;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    t_slot   w_slot [SLOTS];
    t_slot   w_head_next;
    logic    w_hit;
    logic    w_is_run;
    logic    w_is_single;
    logic    w_out_free;
    logic    w_stall;
    logic    w_step;
    logic    w_accept;
    logic    w_fin_has;
    t_result w_hit_res;
    t_result w_fin_res;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Ring of slot cells, head at cell 0, write-back at the tail
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        t_slot w_in;
        if (k == SLOTS - 1) begin : g_tail
            assign w_in = w_head_next;
        end else begin : g_mid
            assign w_in = w_slot[k+1];
        end
        dat_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_step),
            .i_slot  (w_in),
            .o_slot  (w_slot[k])
        );
    end

    dat_head u_head (
        .i_cmd        (r_cmd),
        .i_action_id  (r_action_id),
        .i_argument   (r_argument),
        .i_kind       (r_kind),
        .i_fuse_time  (r_fuse_time),
        .i_time_delta (r_time_delta),
        .i_found      (r_pend_valid),
        .i_slot       (w_slot[0]),
        .o_slot       (w_head_next),
        .o_hit        (w_hit)
    );

    assign w_is_run    = (r_cmd == CMD_RUN_DAEMONS) || (r_cmd == CMD_RUN_FUSES);
    assign w_is_single = (r_cmd == CMD_START_DAEMON) || (r_cmd == CMD_START_FUSE)
                      || (r_cmd == CMD_REMOVE) || (r_cmd == CMD_LENGTHEN);
    assign w_out_free  = !r_out_valid || m_axis_tready;

    // Result for the slot at the head
    always_comb begin
        w_hit_res            = '0;
        w_hit_res.fired      = w_is_run;
        w_hit_res.action     = w_is_run ? w_slot[0].action : '0;
        w_hit_res.argument   = w_is_run ? w_slot[0].argument : '0;
        w_hit_res.slot_index = SLOT_IDX_W'(r_cnt);
        w_hit_res.status     = STATUS_OK;
    end

    // Final result: the held one, or a status report when a single-result command matched nothing
    assign w_fin_has = r_pend_valid || w_is_single;
    always_comb begin
        if (r_pend_valid) begin
            w_fin_res = r_pend;
        end else begin
            w_fin_res        = '0;
            w_fin_res.status = ((r_cmd == CMD_START_DAEMON) || (r_cmd == CMD_START_FUSE))
                             ? STATUS_FULL : STATUS_NOT_FOUND;
        end
        w_fin_res.last = 1'b1;
    end

    // Hold the ring while a new hit meets a held result that cannot leave
    assign w_stall = w_hit && r_pend_valid && !w_out_free;
    assign w_step  = (r_state == ST_PASS) && !w_stall;

    // Sequencer and output register
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state      = ST_PASS;
                    n_cnt        = '0;
                    n_pend_valid = 1'b0;
                end
            end
            ST_PASS: begin
                if (w_step) begin
                    n_cnt = r_cnt + CW'(1);
                    if (w_hit) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_pend;
                            n_out.last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend       = w_hit_res;
                    end
                    if (r_cnt == LAST_SLOT) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!w_fin_has) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = w_fin_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Capture the command and hold the result payloads
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd        <= s_axis_tuser[2:0];
            r_kind       <= s_axis_tuser[4:3];
            r_action_id  <= s_axis_tdata[7:0];
            r_argument   <= s_axis_tdata[23:8];
            r_fuse_time  <= s_axis_tdata[39:24];
            r_time_delta <= s_axis_tdata[55:40];
        end
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.status, r_out.slot_index, r_out.argument,
                            r_out.action};
    assign m_axis_tuser  = r_out.fired;
    assign m_axis_tlast  = r_out.last;

    `ASSERT_NEXT(a_accept_starts_pass, i_clk, i_rst_n, w_accept,
        (r_state == ST_PASS) && (r_cnt == '0) && !r_pend_valid,
        "accepted command did not start a pass at slot zero")
    `ASSERT_ALWAYS(a_fire_only_on_run, i_clk, i_rst_n,
        !(r_pend_valid && r_pend.fired) || w_is_run,
        "held fire result from a command that is not a run")
    `ASSERT_NEXT(a_done_leaves, i_clk, i_rst_n, r_state == ST_DONE,
        (r_state == ST_DONE) || (r_state == ST_IDLE),
        "finish state left to a state other than idle")
    `ASSERT_ALWAYS(a_single_no_early_push, i_clk, i_rst_n,
        !(w_is_single && r_state == ST_PASS && w_hit && r_pend_valid),
        "second match seen for a single-result command")

endmodule

`default_nettype wire
